@@ hdl/bdpm_pkg.sv @@
// Shared types and constants of the bit deque pattern matcher.
// Used by the channel interfaces, the cell, the cell row, the controller and the top level.
// No dependencies.
package bdpm_pkg;

   // Default depth of the bit store.
   localparam int CAPACITY_DEF = 64;

   // Fixed field widths of the request and response channels.
   localparam int OPCODE_W = 3;
   localparam int PAT_W    = 64;
   localparam int PLEN_W   = 7;
   localparam int POS_W    = 6;
   localparam int CNT_W    = 7;

   // Request opcodes. Code 7 carries no operation.
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_END   = 3'd1,
      OP_PUT_EMPTY  = 3'd2,
      OP_FIND       = 3'd3,
      OP_PREFIX     = 3'd4,
      OP_SUFFIX     = 3'd5,
      OP_LOCATE     = 3'd6
   } opcode_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Command broadcast to every cell of the row.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_FRONT,
      CELL_ROTATE,
      CELL_WRITE_END
   } cell_cmd_type;

   // Control group from the controller to the cell row.
   typedef struct packed {
      cell_cmd_type     cmd;
      logic             new_bit;
      logic [CNT_W-1:0] fill;
      logic [CNT_W-1:0] mask_len;
   } row_ctrl_type;

   // One response item.
   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] stored_length;
      logic [CNT_W-1:0] zero_count;
      logic [CNT_W-1:0] one_count;
   } result_type;

endpackage

@@ hdl/bdpm_req_if.sv @@
// Request channel of the bit deque pattern matcher: valid, ready and payload.
// Depends on bdpm_pkg for the field widths.
interface bdpm_req_if import bdpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic                bit_value;
   logic [PAT_W-1:0]    pattern;
   logic [PLEN_W-1:0]   pattern_length;

   modport source (output valid, output opcode, output bit_value, output pattern,
                   output pattern_length, input ready);
   modport sink (input valid, input opcode, input bit_value, input pattern,
                 input pattern_length, output ready);
endinterface

@@ hdl/bdpm_rsp_if.sv @@
// Response channel of the bit deque pattern matcher: valid, ready and payload.
// Depends on bdpm_pkg for the field widths.
interface bdpm_rsp_if import bdpm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             ok;
   logic [POS_W-1:0] position;
   logic [CNT_W-1:0] stored_length;
   logic [CNT_W-1:0] zero_count;
   logic [CNT_W-1:0] one_count;

   modport source (output valid, output ok, output position, output stored_length,
                   output zero_count, output one_count, input ready);
   modport sink (input valid, input ok, input position, input stored_length,
                 input zero_count, input one_count, output ready);
endinterface

@@ hdl/bit_deque_pattern_matcher_top.sv @@
// Top level of the bit deque pattern matcher: controller, cell row and output register.
// Depends on bdpm_pkg, bdpm_req_if, bdpm_rsp_if, bdpm_ctrl and bdpm_cell_row.
//
// Usage:
//   Requests arrive on req_if (valid/ready); each one yields exactly one response
//   on rsp_if (valid/ready), in request order. The block keeps a bit string of up
//   to CAPACITY bits in a row of one-bit cells plus zero and one counts.
//   Push, put and every request that is settled without a search answer in the cycle
//   after acceptance. Find, prefix and suffix searches walk the stored string past
//   the pattern by rotating the cell row one position per cycle, one offset for each
//   cell of the row, and answer after the last offset. Locate slides the pattern past
//   the row one bit per cycle, one offset for each bit of the pattern, and answers
//   after the last offset. One item is in work at a time; the scan length is set by
//   CAPACITY for the rotating searches and by PAT_W for locate.
//   The response sits in an output register; a new request is taken while a
//   finished response is being taken in the same cycle. A stalled receiver holds
//   the response and blocks new requests.
//   Synchronous reset empties the string and clears the counts and the response valid.
module bit_deque_pattern_matcher_top import bdpm_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bdpm_req_if.sink   req_if,
   bdpm_rsp_if.source rsp_if
);

   row_ctrl_type        row_ctrl;
   logic [CAPACITY-1:0] row_pattern;
   logic                row_match;
   logic                res_load;
   result_type          res;
   logic                out_free;

   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff;

   bdpm_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .out_free    (out_free),
      .row_match   (row_match),
      .row_ctrl    (row_ctrl),
      .row_pattern (row_pattern),
      .res_load    (res_load),
      .res         (res)
   );

   bdpm_cell_row #(.CAPACITY(CAPACITY)) u_row (
      .clock       (clock),
      .row_ctrl    (row_ctrl),
      .row_pattern (row_pattern),
      .row_match   (row_match)
   );

   // Output register: free when empty or when its response leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.ok            = rsp_data_ff.ok;
   assign rsp_if.position      = rsp_data_ff.position;
   assign rsp_if.stored_length = rsp_data_ff.stored_length;
   assign rsp_if.zero_count    = rsp_data_ff.zero_count;
   assign rsp_if.one_count     = rsp_data_ff.one_count;

`ifndef SYNTHESIS
   // A new result never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("result loaded over a pending response");

   // The zero and one counts always add up to the stored length.
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_if.zero_count} + {1'b0, rsp_if.one_count}
                        == {1'b0, rsp_if.stored_length}))
      else $error("zero and one counts disagree with stored length");

   // The stored length never exceeds the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_if.stored_length <= CNT_W'(CAPACITY)))
      else $error("stored length above capacity");

   // A request accepted while the output register is busy must see it drain.
   a_accept_drains: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && rsp_valid_ff) |-> rsp_if.ready)
      else $error("request accepted while a response was stalled");
`endif

endmodule

@@ hdl/bdpm_cell.sv @@
// One cell of the bit store: holds one stored bit and compares it with one pattern bit.
// Depends on bdpm_pkg for the cell command type.
module bdpm_cell import bdpm_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         new_bit,
   input  logic         lower_bit,
   input  logic         upper_bit,
   input  logic         write_sel,
   input  logic         pat_bit,
   input  logic         mask_en,
   output logic         bit_out,
   output logic         mismatch
);

   logic bit_ff;
   logic bit_in;

   // Select the next stored bit from the broadcast command.
   always_comb begin
      case (cmd)
         CELL_HOLD:        bit_in = bit_ff;
         CELL_SHIFT_FRONT: bit_in = lower_bit;
         CELL_ROTATE:      bit_in = upper_bit;
         CELL_WRITE_END:   bit_in = write_sel ? new_bit : bit_ff;
         default:          bit_in = bit_ff;
      endcase
   end

   // The stored bit is payload and needs no reset.
   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out  = bit_ff;
   assign mismatch = mask_en & (bit_ff ^ pat_bit);

endmodule

@@ hdl/bdpm_cell_row.sv @@
// Row of bit cells that forms the bit store; cell j holds element j from the front.
// Depends on bdpm_pkg and bdpm_cell.
module bdpm_cell_row import bdpm_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                clock,
   input  row_ctrl_type        row_ctrl,
   input  logic [CAPACITY-1:0] row_pattern,
   output logic                row_match
);

   logic [CAPACITY-1:0] cell_bits;
   logic [CAPACITY-1:0] cell_mismatch;

   genvar j;
   generate
      for (j = 0; j < CAPACITY; j++) begin : g_cell
         logic lower_bit;
         logic upper_bit;
         logic write_sel;
         logic mask_en;

         // Neighbor links: a front push moves bits up, a rotation moves them down
         // and wraps the front bit to the last cell.
         if (j == 0) begin : g_front
            assign lower_bit = row_ctrl.new_bit;
         end else begin : g_inner_low
            assign lower_bit = cell_bits[j-1];
         end
         if (j == CAPACITY - 1) begin : g_back
            assign upper_bit = cell_bits[0];
         end else begin : g_inner_high
            assign upper_bit = cell_bits[j+1];
         end

         // Each cell recognizes its own index for end writes and for the window mask.
         assign write_sel = (row_ctrl.fill == CNT_W'(j));
         assign mask_en   = (CNT_W'(j) < row_ctrl.mask_len);

         bdpm_cell u_cell (
            .clock     (clock),
            .cmd       (row_ctrl.cmd),
            .new_bit   (row_ctrl.new_bit),
            .lower_bit (lower_bit),
            .upper_bit (upper_bit),
            .write_sel (write_sel),
            .pat_bit   (row_pattern[j]),
            .mask_en   (mask_en),
            .bit_out   (cell_bits[j]),
            .mismatch  (cell_mismatch[j])
         );
      end
   endgenerate

   // The window matches when no masked cell disagrees with its pattern bit.
   assign row_match = ~|cell_mismatch;

endmodule

@@ hdl/bdpm_ctrl.sv @@
// Controller of the bit deque pattern matcher: decodes requests, keeps the counts
// and steps the offset scan. Depends on bdpm_pkg and bdpm_req_if.
module bdpm_ctrl import bdpm_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   bdpm_req_if.sink            req_if,
   input  logic                out_free,
   input  logic                row_match,
   output row_ctrl_type        row_ctrl,
   output logic [CAPACITY-1:0] row_pattern,
   output logic                res_load,
   output result_type          res
);

   localparam logic [CNT_W-1:0]  CAP_CNT    = CNT_W'(CAPACITY);
   localparam logic [POS_W-1:0]  LAST_ROT   = POS_W'(CAPACITY - 1);
   localparam logic [POS_W-1:0]  LAST_SLIDE = POS_W'(PAT_W - 1);
   localparam logic [PLEN_W-1:0] PLEN_MAX   = PLEN_W'(PAT_W);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    zeros_ff, zeros_in;
   logic [CNT_W-1:0]    ones_ff, ones_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   logic [PAT_W-1:0]    pat_ff, pat_in;
   logic [POS_W-1:0]    step_ff, step_in;
   logic                ok_ff, ok_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic                req_fire;
   logic [PLEN_W-1:0]   plen_sat;
   logic                start_scan;
   logic                push_ok;
   logic                quick_ok;
   cell_cmd_type        push_cmd;
   logic                scan_last;
   logic                offset_valid;
   logic                offset_hit;

   // Requests are taken only between scans and when the output register can take a result.
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire     = req_if.valid && req_if.ready;
   assign plen_sat     = (req_if.pattern_length > PLEN_MAX) ? PLEN_MAX : req_if.pattern_length;

   // Decode of a new request against the current fill level.
   always_comb begin
      start_scan = 1'b0;
      push_ok    = 1'b0;
      quick_ok   = 1'b0;
      push_cmd   = CELL_HOLD;
      case (req_if.opcode)
         OP_PUSH_FRONT: begin
            if (fill_ff < CAP_CNT) begin
               push_ok  = 1'b1;
               push_cmd = CELL_SHIFT_FRONT;
            end
         end
         OP_PUSH_END: begin
            if (fill_ff < CAP_CNT) begin
               push_ok  = 1'b1;
               push_cmd = CELL_WRITE_END;
            end
         end
         OP_PUT_EMPTY: begin
            if (fill_ff == '0) begin
               push_ok  = 1'b1;
               push_cmd = CELL_WRITE_END;
            end
         end
         OP_FIND, OP_PREFIX, OP_SUFFIX: begin
            if (plen_sat == '0) begin
               quick_ok = 1'b1;
            end else if (plen_sat <= fill_ff) begin
               start_scan = 1'b1;
            end
         end
         OP_LOCATE: begin
            if (fill_ff == '0) begin
               quick_ok = 1'b1;
            end else if (fill_ff <= plen_sat) begin
               start_scan = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Offset i counts only where the window lies inside the string (or the pattern).
   always_comb begin
      case (op_ff)
         OP_FIND:   offset_valid = ({2'b00, step_ff} + {1'b0, plen_ff}) <= {1'b0, fill_ff};
         OP_PREFIX: offset_valid = (step_ff == '0);
         OP_SUFFIX: offset_valid = ({1'b0, step_ff} == (fill_ff - plen_ff));
         OP_LOCATE: offset_valid = ({2'b00, step_ff} + {1'b0, fill_ff}) <= {1'b0, plen_ff};
         default:   offset_valid = 1'b0;
      endcase
   end

   assign offset_hit = offset_valid && row_match;
   assign scan_last  = (step_ff == ((op_ff == OP_LOCATE) ? LAST_SLIDE : LAST_ROT));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && start_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      fill_in  = fill_ff;
      zeros_in = zeros_ff;
      ones_in  = ones_ff;
      op_in    = op_ff;
      plen_in  = plen_ff;
      pat_in   = pat_ff;
      step_in  = step_ff;
      ok_in    = ok_ff;
      pos_in   = pos_ff;

      row_ctrl.cmd      = CELL_HOLD;
      row_ctrl.new_bit  = req_if.bit_value;
      row_ctrl.fill     = fill_ff;
      row_ctrl.mask_len = (op_ff == OP_LOCATE) ? fill_ff : plen_ff;

      res_load           = 1'b0;
      res.ok             = 1'b0;
      res.position       = '0;
      res.stored_length  = fill_ff;
      res.zero_count     = zeros_ff;
      res.one_count      = ones_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_if.opcode;
               plen_in = plen_sat;
               pat_in  = req_if.pattern;
               step_in = '0;
               ok_in   = 1'b0;
               pos_in  = '0;
               if (push_ok) begin
                  row_ctrl.cmd = push_cmd;
                  fill_in      = fill_ff + CNT_W'(1);
                  if (req_if.bit_value) begin
                     ones_in = ones_ff + CNT_W'(1);
                  end else begin
                     zeros_in = zeros_ff + CNT_W'(1);
                  end
               end
               // Everything but a scan loads its result in the cycle of the request.
               if (!start_scan) begin
                  res_load          = 1'b1;
                  res.ok            = push_ok | quick_ok;
                  res.stored_length = fill_in;
                  res.zero_count    = zeros_in;
                  res.one_count     = ones_in;
               end
            end
         end
         ST_SCAN: begin
            // Locate slides the pattern; the other searches rotate the stored string
            // once per offset so that a full pass restores it.
            if (op_ff == OP_LOCATE) begin
               pat_in = pat_ff >> 1;
            end else begin
               row_ctrl.cmd = CELL_ROTATE;
            end
            step_in = step_ff + POS_W'(1);
            if (offset_hit && !ok_ff) begin
               ok_in  = 1'b1;
               pos_in = step_ff;
            end
            if (scan_last) begin
               res_load = 1'b1;
               res.ok   = ok_ff | offset_hit;
               if (op_ff == OP_LOCATE) begin
                  res.position = ok_ff ? pos_ff : (offset_hit ? step_ff : '0);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign row_pattern = pat_ff[CAPACITY-1:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         zeros_ff <= '0;
         ones_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         zeros_ff <= zeros_in;
         ones_ff  <= ones_in;
      end
   end

   // Request and scan working registers.
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      plen_ff <= plen_in;
      pat_ff  <= pat_in;
      step_ff <= step_in;
      ok_ff   <= ok_in;
      pos_ff  <= pos_in;
   end

endmodule
